// ===== rtl/scrc_pkg.sv =====
// Package for the state-count record conditioner.
// Holds widths, register indexes, reset values, the sequencer state type
// and the divider control struct. No dependencies.
package scrc_pkg;

   // Field and datapath widths.
   localparam int COUNT_W   = 32;
   localparam int REG_W     = 16;
   localparam int FRAC_W    = 17;
   localparam int RATIO_W   = 48;
   localparam int MID_W     = 35;
   localparam int MID_SUM_W = 36;
   localparam int SECS_W    = 26;
   localparam int Q_SHIFT   = 16;
   localparam int TIME_FRAC = 10;
   localparam int NUM_W     = 48;
   localparam int DEN_W     = 34;
   localparam int STEP_W    = 6;
   localparam int HALF_W    = 24;
   localparam int PART_W    = REG_W + HALF_W;
   localparam int PROD_W    = 64;
   localparam int CSR_IDX_W = 2;
   localparam int LANE_W    = 2;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DURATION   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DURATION   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SLIP_THRESHOLD = 2'd2;

   // Register reset values.
   localparam logic [REG_W-1:0] MIN_DURATION_RST   = 16'd5120;
   localparam logic [REG_W-1:0] MAX_DURATION_RST   = 16'd15360;
   localparam logic [REG_W-1:0] SLIP_THRESHOLD_RST = 16'd5898;

   // Time conversion constants, in seconds.
   localparam logic [SECS_W-1:0] SECS_PER_DAY    = 26'd86400;
   localparam logic [SECS_W-1:0] SECS_PER_HOUR   = 26'd3600;
   localparam logic [SECS_W-1:0] SECS_PER_MINUTE = 26'd60;

   // Ratio used when the positive count is zero: 999.0 in Q32.16.
   localparam logic [RATIO_W-1:0] NO_POS_RATIO = 48'd999 << Q_SHIFT;

   // Divider iteration counts: full ratio quotient and Q1.16 fraction.
   localparam logic [STEP_W-1:0] DIV_WIDE_STEPS = 6'(NUM_W);
   localparam logic [STEP_W-1:0] DIV_FRAC_STEPS = 6'(FRAC_W);

   // Lane indexes of the four counts.
   localparam logic [LANE_W-1:0] LANE_BIG_POS = 2'd0;
   localparam logic [LANE_W-1:0] LANE_POS     = 2'd1;
   localparam logic [LANE_W-1:0] LANE_LAST    = 2'd3;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_PREP,
      SEQ_MUL,
      SEQ_RATIO_START,
      SEQ_RATIO_WAIT,
      SEQ_FRAC_START,
      SEQ_FRAC_WAIT,
      SEQ_COMPARE
   } seq_state_type;

   typedef struct packed {
      logic start;
      logic wide;
   } div_ctrl_type;

endpackage

// ===== rtl/state_count_record_conditioner_top.sv =====
// Top level of the state-count record conditioner.
// Depends on scrc_pkg and scrc_divider.
//
// Usage: one sampler state-count record is one request transaction on the
// req_ channel (valid/stall). A record whose duration lies outside
// [min_duration, max_duration] is dropped at acceptance with no response
// transaction; only its new_fit rearm takes effect. An accepted record
// yields one rsp_ transaction: midpoint, four count fractions, slip flags.
// The shared one-bit-per-cycle divider does most of the work: after PREP and
// MUL it forms the bigpos/pos ratio (skipped when count_positive is zero),
// then one fraction per count in turn; COMPARE loads the output register
// once it is free. One record is processed at a time with req_stall high
// meanwhile, so a kept record finishes before the next is accepted; a dropped
// record frees the input at once. The response sits in an output register,
// so the next record is accepted while it waits; if rsp_stall still holds it
// when the next result is finished, the sequencer waits with that result.
// Reset (synchronous, active high) loads the register defaults, clears the
// stored ratio, arms the one-shot slip report and drops rsp_valid.
// Configuration registers are written through csr_ only while idle: a rule
// for the user, which the block itself does not enforce.
module state_count_record_conditioner_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_en,
   input  logic [scrc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [scrc_pkg::REG_W-1:0]         csr_wdata,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [8:0]                         req_day_of_year,
   input  logic [4:0]                         req_hour,
   input  logic [5:0]                         req_minute,
   input  logic [15:0]                        req_second_q,
   input  logic [15:0]                        req_duration_q,
   input  logic [scrc_pkg::COUNT_W-1:0]       req_count_big_positive,
   input  logic [scrc_pkg::COUNT_W-1:0]       req_count_positive,
   input  logic [scrc_pkg::COUNT_W-1:0]       req_count_negative,
   input  logic [scrc_pkg::COUNT_W-1:0]       req_count_big_negative,
   input  logic                               req_first_of_channel,
   input  logic                               req_new_fit,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [scrc_pkg::MID_W-1:0]         rsp_mid_time_q,
   output logic [scrc_pkg::FRAC_W-1:0]        rsp_frac_big_positive,
   output logic [scrc_pkg::FRAC_W-1:0]        rsp_frac_positive,
   output logic [scrc_pkg::FRAC_W-1:0]        rsp_frac_negative,
   output logic [scrc_pkg::FRAC_W-1:0]        rsp_frac_big_negative,
   output logic                               rsp_slip_suspect,
   output logic                               rsp_slip_first_report
);

   // Control state.
   scrc_pkg::seq_state_type              state_ff, state_in;
   logic [scrc_pkg::LANE_W-1:0]          lane_ff, lane_in;
   logic [scrc_pkg::REG_W-1:0]           min_dur_ff, min_dur_in;
   logic [scrc_pkg::REG_W-1:0]           max_dur_ff, max_dur_in;
   logic [scrc_pkg::REG_W-1:0]           thr_ff, thr_in;
   logic [scrc_pkg::RATIO_W-1:0]         prev_ratio_ff, prev_ratio_in;
   logic                                 armed_ff, armed_in;
   logic                                 rsp_valid_ff, rsp_valid_in;

   // Captured record.
   logic [8:0]                           day_ff;
   logic [4:0]                           hour_ff;
   logic [5:0]                           minute_ff;
   logic [15:0]                          sec_ff;
   logic [15:0]                          dur_ff;
   logic [scrc_pkg::COUNT_W-1:0]         cnt_ff [4];
   logic                                 first_ff;

   // Working registers.
   logic [scrc_pkg::DEN_W-1:0]           total_ff, total_in;
   logic [scrc_pkg::SECS_W-1:0]          secs_ff, secs_in;
   logic [scrc_pkg::PART_W-1:0]          plo_ff, plo_in;
   logic [scrc_pkg::PART_W-1:0]          phi_ff, phi_in;
   logic [scrc_pkg::MID_W-1:0]           mid_ff, mid_in;
   logic [scrc_pkg::RATIO_W-1:0]         ratio_ff, ratio_in;
   logic [scrc_pkg::FRAC_W-1:0]          frac_ff [4];
   logic [scrc_pkg::RATIO_W-1:0]         diff_ff, diff_in;
   logic [scrc_pkg::PROD_W-1:0]          prod_ff, prod_in;

   // Output register.
   logic [scrc_pkg::MID_W-1:0]           out_mid_ff;
   logic [scrc_pkg::FRAC_W-1:0]          out_frac_ff [4];
   logic                                 out_suspect_ff;
   logic                                 out_report_ff;

   // Combinational helpers.
   logic                                 req_accept;
   logic                                 in_range;
   logic                                 out_free;
   logic                                 capture;
   logic                                 frac_write;
   logic                                 out_load;
   logic                                 suspect;
   logic                                 report;
   logic [8:0]                           day_m1;
   logic [scrc_pkg::DEN_W-1:0]           total_raw;
   logic [scrc_pkg::MID_SUM_W-1:0]       mid_sum;
   scrc_pkg::div_ctrl_type               div_ctrl;
   logic [scrc_pkg::NUM_W-1:0]           div_numer;
   logic [scrc_pkg::DEN_W-1:0]           div_denom;
   logic                                 div_done;
   logic [scrc_pkg::NUM_W-1:0]           div_quotient;

   scrc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .numer    (div_numer),
      .denom    (div_denom),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign req_stall  = (state_ff != scrc_pkg::SEQ_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign in_range   = (req_duration_q >= min_dur_ff) && (req_duration_q <= max_dur_ff);

   // Day zero counts as day one.
   assign day_m1    = (day_ff == 9'd0) ? 9'd0 : day_ff - 9'd1;
   assign total_raw = scrc_pkg::DEN_W'(cnt_ff[0]) + scrc_pkg::DEN_W'(cnt_ff[1])
                    + scrc_pkg::DEN_W'(cnt_ff[2]) + scrc_pkg::DEN_W'(cnt_ff[3]);
   assign mid_sum   = {secs_ff, {scrc_pkg::TIME_FRAC{1'b0}}}
                    + scrc_pkg::MID_SUM_W'(sec_ff)
                    + scrc_pkg::MID_SUM_W'(dur_ff[15:1]);

   // The slip test compares |r - prev| * 2^16 against threshold * prev.
   assign suspect = !first_ff && ({diff_ff, {scrc_pkg::Q_SHIFT{1'b0}}} > prod_ff);
   assign report  = suspect && armed_ff;

   always_comb begin
      state_in      = state_ff;
      lane_in       = lane_ff;
      min_dur_in    = min_dur_ff;
      max_dur_in    = max_dur_ff;
      thr_in        = thr_ff;
      prev_ratio_in = prev_ratio_ff;
      armed_in      = armed_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      total_in      = total_ff;
      secs_in       = secs_ff;
      plo_in        = plo_ff;
      phi_in        = phi_ff;
      mid_in        = mid_ff;
      ratio_in      = ratio_ff;
      diff_in       = diff_ff;
      prod_in       = prod_ff;
      capture       = 1'b0;
      frac_write    = 1'b0;
      out_load      = 1'b0;
      div_ctrl      = '0;
      div_numer     = {cnt_ff[lane_ff], {scrc_pkg::Q_SHIFT{1'b0}}};
      div_denom     = total_ff;

      if (csr_write_en) begin
         case (csr_index)
            scrc_pkg::CSR_MIN_DURATION:   min_dur_in = csr_wdata;
            scrc_pkg::CSR_MAX_DURATION:   max_dur_in = csr_wdata;
            scrc_pkg::CSR_SLIP_THRESHOLD: thr_in     = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         scrc_pkg::SEQ_IDLE: begin
            if (req_accept) begin
               capture = 1'b1;
               if (req_new_fit) begin
                  armed_in = 1'b1;
               end
               if (in_range) begin
                  state_in = scrc_pkg::SEQ_PREP;
               end
            end
         end
         scrc_pkg::SEQ_PREP: begin
            total_in = (total_raw == '0) ? scrc_pkg::DEN_W'(1) : total_raw;
            secs_in  = scrc_pkg::SECS_W'(day_m1) * scrc_pkg::SECS_PER_DAY
                     + scrc_pkg::SECS_W'(hour_ff) * scrc_pkg::SECS_PER_HOUR
                     + scrc_pkg::SECS_W'(minute_ff) * scrc_pkg::SECS_PER_MINUTE;
            plo_in   = scrc_pkg::PART_W'(thr_ff)
                     * scrc_pkg::PART_W'(prev_ratio_ff[scrc_pkg::HALF_W-1:0]);
            state_in = scrc_pkg::SEQ_MUL;
         end
         scrc_pkg::SEQ_MUL: begin
            phi_in   = scrc_pkg::PART_W'(thr_ff)
                     * scrc_pkg::PART_W'(prev_ratio_ff[scrc_pkg::RATIO_W-1:scrc_pkg::HALF_W]);
            mid_in   = mid_sum[scrc_pkg::MID_W-1:0];
            state_in = scrc_pkg::SEQ_RATIO_START;
         end
         scrc_pkg::SEQ_RATIO_START: begin
            lane_in = '0;
            if (cnt_ff[scrc_pkg::LANE_POS] == '0) begin
               ratio_in = scrc_pkg::NO_POS_RATIO;
               state_in = scrc_pkg::SEQ_FRAC_START;
            end else begin
               div_ctrl.start = 1'b1;
               div_ctrl.wide  = 1'b1;
               div_numer      = {cnt_ff[scrc_pkg::LANE_BIG_POS], {scrc_pkg::Q_SHIFT{1'b0}}};
               div_denom      = scrc_pkg::DEN_W'(cnt_ff[scrc_pkg::LANE_POS]);
               state_in       = scrc_pkg::SEQ_RATIO_WAIT;
            end
         end
         scrc_pkg::SEQ_RATIO_WAIT: begin
            if (div_done) begin
               ratio_in = div_quotient;
               state_in = scrc_pkg::SEQ_FRAC_START;
            end
         end
         scrc_pkg::SEQ_FRAC_START: begin
            div_ctrl.start = 1'b1;
            state_in       = scrc_pkg::SEQ_FRAC_WAIT;
         end
         scrc_pkg::SEQ_FRAC_WAIT: begin
            if (div_done) begin
               frac_write = 1'b1;
               lane_in    = lane_ff + 1'b1;
               if (lane_ff == scrc_pkg::LANE_LAST) begin
                  diff_in  = (ratio_ff >= prev_ratio_ff) ? ratio_ff - prev_ratio_ff
                                                         : prev_ratio_ff - ratio_ff;
                  prod_in  = {phi_ff, {scrc_pkg::HALF_W{1'b0}}}
                           + scrc_pkg::PROD_W'(plo_ff);
                  state_in = scrc_pkg::SEQ_COMPARE;
               end else begin
                  state_in = scrc_pkg::SEQ_FRAC_START;
               end
            end
         end
         scrc_pkg::SEQ_COMPARE: begin
            // Hold the finished result until the output register is free.
            if (out_free) begin
               out_load      = 1'b1;
               rsp_valid_in  = 1'b1;
               prev_ratio_in = ratio_ff;
               if (report) begin
                  armed_in = 1'b0;
               end
               state_in = scrc_pkg::SEQ_IDLE;
            end
         end
         default: state_in = scrc_pkg::SEQ_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= scrc_pkg::SEQ_IDLE;
         lane_ff       <= '0;
         min_dur_ff    <= scrc_pkg::MIN_DURATION_RST;
         max_dur_ff    <= scrc_pkg::MAX_DURATION_RST;
         thr_ff        <= scrc_pkg::SLIP_THRESHOLD_RST;
         prev_ratio_ff <= '0;
         armed_ff      <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         lane_ff       <= lane_in;
         min_dur_ff    <= min_dur_in;
         max_dur_ff    <= max_dur_in;
         thr_ff        <= thr_in;
         prev_ratio_ff <= prev_ratio_in;
         armed_ff      <= armed_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      total_ff <= total_in;
      secs_ff  <= secs_in;
      plo_ff   <= plo_in;
      phi_ff   <= phi_in;
      mid_ff   <= mid_in;
      ratio_ff <= ratio_in;
      diff_ff  <= diff_in;
      prod_ff  <= prod_in;
      if (capture) begin
         day_ff    <= req_day_of_year;
         hour_ff   <= req_hour;
         minute_ff <= req_minute;
         sec_ff    <= req_second_q;
         dur_ff    <= req_duration_q;
         cnt_ff[0] <= req_count_big_positive;
         cnt_ff[1] <= req_count_positive;
         cnt_ff[2] <= req_count_negative;
         cnt_ff[3] <= req_count_big_negative;
         first_ff  <= req_first_of_channel;
      end
      if (frac_write) begin
         frac_ff[lane_ff] <= div_quotient[scrc_pkg::FRAC_W-1:0];
      end
      if (out_load) begin
         out_mid_ff     <= mid_ff;
         out_frac_ff[0] <= frac_ff[0];
         out_frac_ff[1] <= frac_ff[1];
         out_frac_ff[2] <= frac_ff[2];
         out_frac_ff[3] <= frac_ff[3];
         out_suspect_ff <= suspect;
         out_report_ff  <= report;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_mid_time_q        = out_mid_ff;
   assign rsp_frac_big_positive = out_frac_ff[0];
   assign rsp_frac_positive     = out_frac_ff[1];
   assign rsp_frac_negative     = out_frac_ff[2];
   assign rsp_frac_big_negative = out_frac_ff[3];
   assign rsp_slip_suspect      = out_suspect_ff;
   assign rsp_slip_first_report = out_report_ff;

`ifndef SYNTHESIS
   a_report_needs_suspect: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!out_report_ff || out_suspect_ff))
      else $error("first report without a suspect");

   a_result_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == scrc_pkg::SEQ_COMPARE && out_free)
         |=> (rsp_valid_ff && state_ff == scrc_pkg::SEQ_IDLE))
      else $error("finished result not presented");

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == scrc_pkg::SEQ_RATIO_WAIT
                    || state_ff == scrc_pkg::SEQ_FRAC_WAIT))
      else $error("divider finished outside a wait state");

   a_report_disarms: assert property (@(posedge clock) disable iff (reset)
      (out_load && report) |=> !armed_ff)
      else $error("report left the one-shot armed");
`endif

endmodule

// ===== rtl/scrc_divider.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on scrc_pkg for widths and iteration counts.
module scrc_divider (
   input  logic                            clock,
   input  logic                            reset,
   input  scrc_pkg::div_ctrl_type          ctrl,
   input  logic [scrc_pkg::NUM_W-1:0]      numer,
   input  logic [scrc_pkg::DEN_W-1:0]      denom,
   output logic                            done,
   output logic [scrc_pkg::NUM_W-1:0]      quotient
);

   logic                            run_ff, run_in;
   logic                            done_ff, done_in;
   logic [scrc_pkg::STEP_W-1:0]     cnt_ff, cnt_in;
   logic [scrc_pkg::DEN_W-1:0]      rem_ff, rem_in;
   logic [scrc_pkg::DEN_W-1:0]      den_ff, den_in;
   logic [scrc_pkg::NUM_W-1:0]      num_ff, num_in;
   logic [scrc_pkg::NUM_W-1:0]      quo_ff, quo_in;
   logic [scrc_pkg::DEN_W:0]        trial;
   logic [scrc_pkg::DEN_W:0]        trial_sub;
   logic                            fits;

   always_comb begin
      trial     = {rem_ff, num_ff[scrc_pkg::NUM_W-1]};
      fits      = trial >= {1'b0, den_ff};
      trial_sub = trial - {1'b0, den_ff};
      run_in    = run_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      num_in    = num_ff;
      quo_in    = quo_ff;
      if (ctrl.start) begin
         run_in = 1'b1;
         den_in = denom;
         quo_in = '0;
         if (ctrl.wide) begin
            rem_in = '0;
            num_in = numer;
            cnt_in = scrc_pkg::DIV_WIDE_STEPS;
         end else begin
            // The upper bits of the dividend are known to lie below the divisor.
            rem_in = scrc_pkg::DEN_W'(numer[scrc_pkg::NUM_W-1:scrc_pkg::FRAC_W]);
            num_in = {numer[scrc_pkg::FRAC_W-1:0],
                      {(scrc_pkg::NUM_W-scrc_pkg::FRAC_W){1'b0}}};
            cnt_in = scrc_pkg::DIV_FRAC_STEPS;
         end
      end else if (run_ff) begin
         rem_in = fits ? trial_sub[scrc_pkg::DEN_W-1:0] : trial[scrc_pkg::DEN_W-1:0];
         num_in = {num_ff[scrc_pkg::NUM_W-2:0], 1'b0};
         quo_in = {quo_ff[scrc_pkg::NUM_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == scrc_pkg::STEP_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

`ifndef SYNTHESIS
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      ctrl.start |-> !run_ff)
      else $error("divider started while busy");

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      run_ff |-> (rem_ff < den_ff))
      else $error("partial remainder not below divisor");

   a_done_after_run: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (!run_ff && $past(run_ff)))
      else $error("done without a finished run");
`endif

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the state-count record conditioner.
// Depends on scrc_pkg and state_count_record_conditioner_top; predicts every
// response transaction and compares it field by field.
module tb;

   localparam int HOLD_CYCLES  = 600;    // long receiver hold-off
   localparam int SETTLE_WAIT  = 160;    // a little over the worst latency
   localparam int SETTLE_GUARD = 20000;  // cycles to wait for missing results
   localparam int REPORT_LINES = 100;    // mismatch lines printed at most

   typedef struct packed {
      logic [8:0]                   day_of_year;
      logic [4:0]                   hour;
      logic [5:0]                   minute;
      logic [15:0]                  second_q;
      logic [15:0]                  duration_q;
      logic [scrc_pkg::COUNT_W-1:0] count_big_positive;
      logic [scrc_pkg::COUNT_W-1:0] count_positive;
      logic [scrc_pkg::COUNT_W-1:0] count_negative;
      logic [scrc_pkg::COUNT_W-1:0] count_big_negative;
      logic                         first_of_channel;
      logic                         new_fit;
   } record_type;

   typedef struct packed {
      logic [scrc_pkg::MID_W-1:0]  mid_time_q;
      logic [scrc_pkg::FRAC_W-1:0] frac_big_positive;
      logic [scrc_pkg::FRAC_W-1:0] frac_positive;
      logic [scrc_pkg::FRAC_W-1:0] frac_negative;
      logic [scrc_pkg::FRAC_W-1:0] frac_big_negative;
      logic                        slip_suspect;
      logic                        slip_first_report;
   } result_type;

   // Holds a private copy of the registers and of the slip state, and the
   // responses still owed by the block, oldest first.
   class conditioner_scoreboard;
      bit [63:0]  min_dur;
      bit [63:0]  max_dur;
      bit [63:0]  slip_thr;
      bit [63:0]  last_ratio;
      bit         armed;
      result_type expected_results[$];
      int         mismatches;

      function new();
         min_dur    = 64'(scrc_pkg::MIN_DURATION_RST);
         max_dur    = 64'(scrc_pkg::MAX_DURATION_RST);
         slip_thr   = 64'(scrc_pkg::SLIP_THRESHOLD_RST);
         last_ratio = 0;
         armed      = 1'b1;
         mismatches = 0;
      endfunction

      function void set_register(logic [scrc_pkg::CSR_IDX_W-1:0] idx,
                                 logic [scrc_pkg::REG_W-1:0] val);
         case (idx)
            scrc_pkg::CSR_MIN_DURATION:   min_dur  = 64'(val);
            scrc_pkg::CSR_MAX_DURATION:   max_dur  = 64'(val);
            scrc_pkg::CSR_SLIP_THRESHOLD: slip_thr = 64'(val);
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      task report(string what);
         if (mismatches < REPORT_LINES) begin
            $display("mismatch at %0t: %s", $realtime, what);
         end
         mismatches++;
      endtask

      // Notes an accepted record and predicts the response it gives, if any.
      function void note_record(record_type r);
         bit [63:0]  day, secs, total, ratio, diff, bp, p, n, bn;
         result_type e;
         if (r.new_fit) begin
            armed = 1'b1;
         end
         if (r.duration_q < min_dur || r.duration_q > max_dur) begin
            return;
         end
         day  = (r.day_of_year == 0) ? 64'd1 : 64'(r.day_of_year);
         secs = (day - 1) * 86400 + 64'(r.hour) * 3600 + 64'(r.minute) * 60;
         e.mid_time_q = 35'((secs << 10) + 64'(r.second_q) + (64'(r.duration_q) >> 1));
         bp = 64'(r.count_big_positive);
         p  = 64'(r.count_positive);
         n  = 64'(r.count_negative);
         bn = 64'(r.count_big_negative);
         total = bp + p + n + bn;
         if (total == 0) begin
            total = 1;
         end
         // A record with no positive counts gets the fixed ratio 999.0.
         ratio = (p != 0) ? ((bp << 16) / p) : (64'd999 << 16);
         e.slip_suspect      = 1'b0;
         e.slip_first_report = 1'b0;
         if (!r.first_of_channel) begin
            diff = (ratio >= last_ratio) ? ratio - last_ratio : last_ratio - ratio;
            e.slip_suspect = (diff << 16) > (slip_thr * last_ratio);
            if (e.slip_suspect && armed) begin
               e.slip_first_report = 1'b1;
               armed = 1'b0;
            end
         end
         last_ratio = ratio;
         e.frac_big_positive = 17'((bp << 16) / total);
         e.frac_positive     = 17'((p << 16) / total);
         e.frac_negative     = 17'((n << 16) / total);
         e.frac_big_negative = 17'((bn << 16) / total);
         expected_results.push_back(e);
      endfunction

      task check_result(result_type got);
         result_type  e;
         logic [63:0] g[7];
         logic [63:0] w[7];
         string       names[7];
         if (expected_results.size() == 0) begin
            report("response transaction with no record waiting for it");
            return;
         end
         e = expected_results.pop_front();
         names = '{"mid_time_q", "frac_big_positive", "frac_positive", "frac_negative",
                   "frac_big_negative", "slip_suspect", "slip_first_report"};
         g = '{64'(got.mid_time_q), 64'(got.frac_big_positive), 64'(got.frac_positive),
               64'(got.frac_negative), 64'(got.frac_big_negative), 64'(got.slip_suspect),
               64'(got.slip_first_report)};
         w = '{64'(e.mid_time_q), 64'(e.frac_big_positive), 64'(e.frac_positive),
               64'(e.frac_negative), 64'(e.frac_big_negative), 64'(e.slip_suspect),
               64'(e.slip_first_report)};
         for (int i = 0; i < 7; i++) begin
            if (g[i] !== w[i]) begin
               report($sformatf("%s got %0h expected %0h", names[i], g[i], w[i]));
            end
         end
      endtask
   endclass

   logic                           clock;
   logic                           reset = 1'b1;
   logic                           csr_write_en = 1'b0;
   logic [scrc_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [scrc_pkg::REG_W-1:0]     csr_wdata = '0;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   record_type                     offered = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic [scrc_pkg::MID_W-1:0]     rsp_mid_time_q;
   logic [scrc_pkg::FRAC_W-1:0]    rsp_frac_big_positive;
   logic [scrc_pkg::FRAC_W-1:0]    rsp_frac_positive;
   logic [scrc_pkg::FRAC_W-1:0]    rsp_frac_negative;
   logic [scrc_pkg::FRAC_W-1:0]    rsp_frac_big_negative;
   logic                           rsp_slip_suspect;
   logic                           rsp_slip_first_report;
   result_type                     observed;

   conditioner_scoreboard sb = new();

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   bit hold_request   = 1'b0;
   int kept_records   = 0;

   assign observed = {rsp_mid_time_q, rsp_frac_big_positive, rsp_frac_positive,
                      rsp_frac_negative, rsp_frac_big_negative, rsp_slip_suspect,
                      rsp_slip_first_report};

   state_count_record_conditioner_top dut (
      .clock                  (clock),
      .reset                  (reset),
      .csr_write_en           (csr_write_en),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_day_of_year        (offered.day_of_year),
      .req_hour               (offered.hour),
      .req_minute             (offered.minute),
      .req_second_q           (offered.second_q),
      .req_duration_q         (offered.duration_q),
      .req_count_big_positive (offered.count_big_positive),
      .req_count_positive     (offered.count_positive),
      .req_count_negative     (offered.count_negative),
      .req_count_big_negative (offered.count_big_negative),
      .req_first_of_channel   (offered.first_of_channel),
      .req_new_fit            (offered.new_fit),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_mid_time_q         (rsp_mid_time_q),
      .rsp_frac_big_positive  (rsp_frac_big_positive),
      .rsp_frac_positive      (rsp_frac_positive),
      .rsp_frac_negative      (rsp_frac_negative),
      .rsp_frac_big_negative  (rsp_frac_big_negative),
      .rsp_slip_suspect       (rsp_slip_suspect),
      .rsp_slip_first_report  (rsp_slip_first_report)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Both channels are watched at the rising edge, where the values seen are
   // the ones the block samples.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_result(observed);
      end
      if (!reset && req_valid && !req_stall) begin
         sb.note_record(offered);
      end
   end

   // Receiver. A hold request makes it stall for a long stretch so that the
   // output register fills and the block pushes back on its input.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            repeat (HOLD_CYCLES) begin
               rsp_stall <= 1'b1;
               @(negedge clock);
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   initial begin
      #10_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // Offers one record and returns once the block has taken it.
   task automatic send_record(record_type r);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      offered   <= r;
      do @(posedge clock); while (req_stall);
      if (r.duration_q >= sb.min_dur && r.duration_q <= sb.max_dur) begin
         kept_records++;
      end
   endtask

   task automatic stop_sending();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic write_register(logic [scrc_pkg::CSR_IDX_W-1:0] idx,
                                 logic [scrc_pkg::REG_W-1:0] val);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(negedge clock);
      csr_write_en <= 1'b0;
      sb.set_register(idx, val);
   endtask

   // Waits for every owed response, then lets the block run dry.
   task automatic settle();
      int guard;
      guard = 0;
      while (sb.pending() != 0 && guard < SETTLE_GUARD) begin
         @(posedge clock);
         guard++;
      end
      if (sb.pending() != 0) begin
         sb.report($sformatf("%0d expected responses never arrived", sb.pending()));
         sb.expected_results.delete();
      end
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   function automatic record_type record_of(int day, int hr, int mn, int sec, int dur,
                                            bit [31:0] bp, bit [31:0] p, bit [31:0] n,
                                            bit [31:0] bn, bit first, bit fit);
      record_type r;
      r.day_of_year        = 9'(day);
      r.hour               = 5'(hr);
      r.minute             = 6'(mn);
      r.second_q           = 16'(sec);
      r.duration_q         = 16'(dur);
      r.count_big_positive = bp;
      r.count_positive     = p;
      r.count_negative     = n;
      r.count_big_negative = bn;
      r.first_of_channel   = first;
      r.new_fit            = fit;
      return r;
   endfunction

   // Sensible start time; the duration mostly lies inside the current limits,
   // sometimes on or just past an edge, sometimes anywhere.
   function automatic record_type timed_record();
      record_type r;
      int         pick;
      bit [15:0]  lo, hi;
      r = '0;
      r.day_of_year = 9'($urandom_range(366, 1));
      r.hour        = 5'($urandom_range(23, 0));
      r.minute      = 6'($urandom_range(59, 0));
      r.second_q    = 16'($urandom_range(61439, 0));
      lo   = 16'(sb.min_dur);
      hi   = 16'(sb.max_dur);
      pick = $urandom_range(99);
      if (lo <= hi && pick < 82) begin
         r.duration_q = 16'($urandom_range(hi, lo));
      end else if (pick < 91) begin
         case ($urandom_range(3))
            0: r.duration_q = lo;
            1: r.duration_q = hi;
            2: r.duration_q = lo - 16'd1;
            default: r.duration_q = hi + 16'd1;
         endcase
      end else begin
         r.duration_q = 16'($urandom);
      end
      return r;
   endfunction

   function automatic record_type noise_record();
      record_type r;
      r.day_of_year        = 9'($urandom);
      r.hour               = 5'($urandom);
      r.minute             = 6'($urandom);
      r.second_q           = 16'($urandom);
      r.duration_q         = 16'($urandom);
      r.count_big_positive = $urandom;
      r.count_positive     = $urandom;
      r.count_negative     = $urandom;
      r.count_big_negative = $urandom;
      r.first_of_channel   = 1'($urandom);
      r.new_fit            = 1'($urandom);
      return r;
   endfunction

   // One channel: a first record, then records whose bigpos/pos ratio drifts
   // a little around a base value, with an occasional jump that looks like a
   // byte slip. A few channels leave out the first-record mark.
   task automatic send_channel(int len);
      record_type r;
      bit [63:0]  base, rn, p;
      bit         skip_first;
      base       = 64'($urandom_range(400, 16));
      skip_first = ($urandom_range(9) == 0);
      for (int i = 0; i < len; i++) begin
         r = timed_record();
         if ($urandom_range(99) < 12) begin
            rn = base * 64'($urandom_range(170, 40)) / 100;
         end else begin
            rn = base * 64'($urandom_range(104, 96)) / 100;
         end
         if (rn > 511) begin
            rn = 511;
         end
         p = 64'($urandom_range(32'h7FFF_FFFF, 1)) >> $urandom_range(28, 0);
         if ($urandom_range(39) == 0) begin
            p = 0;
         end
         r.count_positive     = 32'(p);
         r.count_big_positive = 32'((p * rn) >> 8);
         r.count_negative     = 32'((p * 64'($urandom_range(511, 0))) >> 8);
         r.count_big_negative = 32'((p * 64'($urandom_range(511, 0))) >> 8);
         r.first_of_channel   = (i == 0) && !skip_first;
         r.new_fit            = (i == 0 && $urandom_range(3) == 0) || ($urandom_range(19) == 0);
         send_record(r);
      end
   endtask

   // Sends channels mixed with noise until enough records were kept.
   task automatic run_random(int goal);
      int start;
      start = kept_records;
      while (kept_records - start < goal) begin
         if ($urandom_range(99) < 15) begin
            send_record(noise_record());
         end else begin
            send_channel($urandom_range(12, 3));
         end
      end
      stop_sending();
   endtask

   // Directed records under the reset limits. Before any first record the
   // comparison runs against a zero ratio; the one-shot report, its rearm by
   // a dropped record, the exact threshold edge, a zero positive count, a
   // zero total, full-scale counts and out-of-range time fields follow.
   task automatic run_directed();
      send_record(record_of(1, 0, 0, 0, 5120, 100, 100, 100, 100, 0, 0));
      send_record(record_of(1, 0, 0, 0, 15360, 200, 100, 0, 0, 0, 0));
      send_record(record_of(1, 0, 0, 0, 5119, 5, 5, 5, 5, 0, 1));
      send_record(record_of(1, 0, 0, 0, 15361, 5, 5, 5, 5, 0, 0));
      send_record(record_of(1, 0, 0, 0, 0, 5, 5, 5, 5, 0, 0));
      send_record(record_of(1, 0, 0, 0, 65535, 5, 5, 5, 5, 0, 0));
      send_record(record_of(2, 1, 1, 1, 10240, 1000, 1000, 0, 0, 1, 0));
      send_record(record_of(2, 1, 1, 1, 10240, 71434, 65536, 0, 0, 0, 0));
      send_record(record_of(2, 1, 1, 1, 10240, 7, 7, 0, 0, 1, 0));
      send_record(record_of(2, 1, 1, 1, 10240, 71435, 65536, 0, 0, 0, 0));
      send_record(record_of(3, 2, 3, 4, 10240, 32'hFFFF_FFFF, 0, 0, 0, 0, 0));
      send_record(record_of(3, 2, 3, 4, 10240, 0, 0, 0, 0, 0, 0));
      send_record(record_of(4, 5, 6, 7, 10240, 0, 5, 0, 0, 1, 0));
      send_record(record_of(4, 5, 6, 7, 10240, 0, 9, 0, 0, 0, 0));
      send_record(record_of(4, 5, 6, 7, 10240, 32'hFFFF_FFFF, 1, 0, 0, 0, 1));
      send_record(record_of(5, 0, 0, 0, 10240, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0));
      send_record(record_of(5, 0, 0, 0, 10240, 0, 32'hFFFF_FFFF, 0, 0, 1, 0));
      send_record(record_of(5, 0, 0, 0, 10240, 0, 0, 32'hFFFF_FFFF, 0, 1, 0));
      send_record(record_of(5, 0, 0, 0, 10240, 0, 0, 0, 32'hFFFF_FFFF, 1, 0));
      send_record(record_of(0, 0, 0, 0, 10240, 1, 1, 1, 1, 1, 0));
      send_record(record_of(366, 23, 59, 61439, 15360, 1, 2, 0, 0, 1, 0));
      send_record(record_of(511, 31, 63, 65535, 15360, 3, 1, 4, 1, 0, 0));
      stop_sending();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset limits, no idling on either side.
      run_directed();
      run_random(130);
      settle();

      // Widest limits and a zero threshold; the sender idles and the
      // receiver holds off for a long stretch at the start.
      write_register(scrc_pkg::CSR_MIN_DURATION, 16'd0);
      write_register(scrc_pkg::CSR_MAX_DURATION, 16'hFFFF);
      write_register(scrc_pkg::CSR_SLIP_THRESHOLD, 16'd0);
      send_idle_pct  = 52;
      recv_stall_pct = 0;
      hold_request   = 1'b1;
      run_random(130);
      settle();

      // A single accepted duration and the largest threshold; receiver stalls.
      write_register(scrc_pkg::CSR_MIN_DURATION, 16'd10240);
      write_register(scrc_pkg::CSR_MAX_DURATION, 16'd10240);
      write_register(scrc_pkg::CSR_SLIP_THRESHOLD, 16'hFFFF);
      send_idle_pct  = 0;
      recv_stall_pct = 52;
      run_random(100);
      settle();

      // Crossed limits drop every record; only the rearm survives.
      write_register(scrc_pkg::CSR_MIN_DURATION, 16'd20000);
      write_register(scrc_pkg::CSR_MAX_DURATION, 16'd1000);
      send_idle_pct  = 22;
      recv_stall_pct = 22;
      for (int i = 0; i < 20; i++) begin
         send_record(timed_record());
      end
      stop_sending();
      settle();

      // Moderate limits around the defaults, both sides idling.
      write_register(scrc_pkg::CSR_MIN_DURATION, 16'd3000);
      write_register(scrc_pkg::CSR_MAX_DURATION, 16'd40000);
      write_register(scrc_pkg::CSR_SLIP_THRESHOLD, 16'd5898);
      run_random(170);
      settle();

      if (sb.mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
